// File: sv/wspe_pkg.sv
// Shared types, constants and arithmetic helpers for the subpixel plot engine.
package wspe_pkg;

	localparam int MATRIX_WIDTH  = 16;
	localparam int MATRIX_HEIGHT = 16;
	localparam int PIX_COUNT     = MATRIX_WIDTH * MATRIX_HEIGHT;
	localparam int ADDR_W        = (PIX_COUNT > 1) ? $clog2(PIX_COUNT) : 1;
	localparam int CHAN_W        = 8;
	localparam int PIX_W         = 3 * CHAN_W;
	// integer part of a position is 4 bits; one more bit holds the +1 neighbor
	localparam int COORD_W       = 5;
	localparam int QUEUE_DEPTH   = 4;
	localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] CMD_PLOT  = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	typedef enum logic [1:0] {
		OP_PLOT,
		OP_READ,
		OP_CLEAR
	} op_kind_t;

	// one pixel operation handed from the front to the back
	typedef struct packed {
		op_kind_t            kind;
		logic [COORD_W-1:0]  col;
		logic [COORD_W-1:0]  row;
		logic                inb;
		logic [CHAN_W-1:0]   weight;
		logic [CHAN_W-1:0]   red;
		logic [CHAN_W-1:0]   green;
		logic [CHAN_W-1:0]   blue;
		logic                last;
	} op_t;

	// corner weight (a*b + a + b) >> 8
	function automatic logic [CHAN_W-1:0] corner_weight(input logic [CHAN_W-1:0] a,
		input logic [CHAN_W-1:0] b);
		logic [2*CHAN_W:0] p;
		p = (2*CHAN_W+1)'(a) * (2*CHAN_W+1)'(b) + (2*CHAN_W+1)'(a) + (2*CHAN_W+1)'(b);
		return p[2*CHAN_W-1:CHAN_W];
	endfunction

	// scale a channel by a weight and add it into a base value, clamped at full scale
	function automatic logic [CHAN_W-1:0] scale_add(input logic [CHAN_W-1:0] base,
		input logic [CHAN_W-1:0] chan, input logic [CHAN_W-1:0] w);
		logic [2*CHAN_W-1:0] prod;
		logic [CHAN_W:0]     sum;
		prod = chan * w;
		sum  = {1'b0, base} + {1'b0, prod[2*CHAN_W-1:CHAN_W]};
		return sum[CHAN_W] ? {CHAN_W{1'b1}} : sum[CHAN_W-1:0];
	endfunction

	function automatic logic in_matrix(input logic [COORD_W-1:0] col,
		input logic [COORD_W-1:0] row);
		return (int'(col) < MATRIX_WIDTH) && (int'(row) < MATRIX_HEIGHT);
	endfunction

endpackage

// File: sv/wspe_ram.sv
// Generic single-port RAM with registered read data.
module wspe_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic                                 we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                     wdata,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write on we, otherwise register the addressed word
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// File: sv/wspe_front.sv
// Front end: accepts requests, derives weights and neighbors, issues pixel ops.
module wspe_front import wspe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        cmd,
	input  logic [11:0]       x_pos,
	input  logic [11:0]       y_pos,
	input  logic [CHAN_W-1:0] red_in,
	input  logic [CHAN_W-1:0] green_in,
	input  logic [CHAN_W-1:0] blue_in,
	output logic              push,
	output op_t               push_op,
	input  logic              q_full
);

	logic               busy_q;
	logic [3:0]         mask_q;
	op_kind_t           kind_q;
	logic [COORD_W-1:0] c0_q, r0_q;
	logic               inb_q;
	logic [CHAN_W-1:0]  red_q, green_q, blue_q;
	logic [CHAN_W-1:0]  wgt_q [4];

	logic               accept;
	logic [COORD_W-1:0] c0, r0, c1, r1;
	logic [CHAN_W-1:0]  fx, fy, ix, iy;
	logic [3:0]         plot_mask;
	logic [1:0]         sel;
	logic [3:0]         rest;

	assign in_ready = !busy_q;
	assign accept   = in_valid && in_ready;

	// split the incoming position and find which neighbors lie inside the frame
	always_comb begin
		c0 = COORD_W'(x_pos[11:8]);
		r0 = COORD_W'(y_pos[11:8]);
		c1 = c0 + COORD_W'(1);
		r1 = r0 + COORD_W'(1);
		fx = x_pos[7:0];
		fy = y_pos[7:0];
		ix = 8'hff - fx;
		iy = 8'hff - fy;
		plot_mask = {in_matrix(c1, r1), in_matrix(c0, r1), in_matrix(c1, r0),
			in_matrix(c0, r0)};
	end

	// pick the lowest pending neighbor
	always_comb begin
		priority if (mask_q[0]) begin
			sel = 2'd0;
		end else if (mask_q[1]) begin
			sel = 2'd1;
		end else if (mask_q[2]) begin
			sel = 2'd2;
		end else begin
			sel = 2'd3;
		end
		rest = mask_q & ~(4'b0001 << sel);
	end

	// issue one pixel op per cycle while the queue has room
	always_comb begin
		push           = busy_q && !q_full;
		push_op.kind   = kind_q;
		push_op.col    = c0_q + COORD_W'(sel[0]);
		push_op.row    = r0_q + COORD_W'(sel[1]);
		push_op.inb    = inb_q;
		push_op.weight = wgt_q[sel];
		push_op.red    = red_q;
		push_op.green  = green_q;
		push_op.blue   = blue_q;
		push_op.last   = (rest == 4'b0000);
	end

	// track pending neighbors of the held request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			mask_q <= 4'b0000;
			kind_q <= OP_PLOT;
		end else if (accept) begin
			unique case (cmd)
				CMD_PLOT: begin
					busy_q <= |plot_mask;
					mask_q <= plot_mask;
					kind_q <= OP_PLOT;
				end
				CMD_READ: begin
					busy_q <= 1'b1;
					mask_q <= 4'b0001;
					kind_q <= OP_READ;
				end
				CMD_CLEAR: begin
					busy_q <= 1'b1;
					mask_q <= 4'b0001;
					kind_q <= OP_CLEAR;
				end
				default: begin
					busy_q <= 1'b0;
					mask_q <= 4'b0000;
				end
			endcase
		end else if (push) begin
			mask_q <= rest;
			if (rest == 4'b0000) begin
				busy_q <= 1'b0;
			end
		end
	end

	// hold the request payload and its four corner weights
	always_ff @(posedge clk) begin
		if (accept) begin
			c0_q     <= (cmd == CMD_CLEAR) ? '0 : c0;
			r0_q     <= (cmd == CMD_CLEAR) ? '0 : r0;
			inb_q    <= plot_mask[0];
			red_q    <= red_in;
			green_q  <= green_in;
			blue_q   <= blue_in;
			wgt_q[0] <= corner_weight(ix, iy);
			wgt_q[1] <= corner_weight(fx, iy);
			wgt_q[2] <= corner_weight(ix, fy);
			wgt_q[3] <= corner_weight(fx, fy);
		end
	end

endmodule

// File: sv/wspe_queue.sv
// Short FIFO of pixel ops between front and back.
module wspe_queue import wspe_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	output logic full,
	input  logic pop,
	output op_t  head_op,
	output logic empty
);

	op_t                slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	assign full    = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign head_op = slot_q[rd_ptr_q];

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	// store entries
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

// File: sv/wspe_back.sv
// Back end: read-modify-write of the frame store and result register.
module wspe_back import wspe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  op_t               q_op,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [3:0]        pixel_col,
	output logic [3:0]        pixel_row,
	output logic [CHAN_W-1:0] red_out,
	output logic [CHAN_W-1:0] green_out,
	output logic [CHAN_W-1:0] blue_out,
	output logic              last
);

	typedef enum logic {
		B_IDLE,
		B_RMW
	} state_t;

	state_t             state_q;
	op_t                op_q;
	logic [ADDR_W-1:0]  addr_q;
	logic               vld_rd_q;
	logic [PIX_COUNT-1:0] valid_q;

	logic [ADDR_W-1:0]  head_addr;
	logic               rd_en;
	logic               out_free;
	logic               finish;
	logic [PIX_W-1:0]   ram_rdata;
	logic [PIX_W-1:0]   pix;
	logic [PIX_W-1:0]   new_pix;
	logic               ram_en;
	logic               ram_we;
	logic [ADDR_W-1:0]  ram_addr;

	// decode the queue head and the handshake conditions
	always_comb begin
		head_addr = ADDR_W'(int'(q_op.row) * MATRIX_WIDTH + int'(q_op.col));
		pop       = (state_q == B_IDLE) && !q_empty;
		rd_en     = pop && ((q_op.kind == OP_PLOT) || ((q_op.kind == OP_READ) && q_op.inb));
		out_free  = !out_valid || out_ready;
		finish    = (state_q == B_RMW) && out_free;
	end

	// merge the scaled colour into the stored pixel
	always_comb begin
		pix     = vld_rd_q ? ram_rdata : '0;
		new_pix = {scale_add(pix[PIX_W-1:2*CHAN_W], op_q.red, op_q.weight),
			scale_add(pix[2*CHAN_W-1:CHAN_W], op_q.green, op_q.weight),
			scale_add(pix[CHAN_W-1:0], op_q.blue, op_q.weight)};
		ram_we   = finish && (op_q.kind == OP_PLOT);
		ram_en   = rd_en || ram_we;
		ram_addr = ram_we ? addr_q : head_addr;
	end

	wspe_ram #(
		.WIDTH(PIX_W),
		.DEPTH(PIX_COUNT)
	) u_frame (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (new_pix),
		.rdata (ram_rdata)
	);

	// sequence each op and load the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			op_q      <= '0;
			addr_q    <= '0;
			vld_rd_q  <= 1'b0;
			valid_q   <= '0;
			out_valid <= 1'b0;
			pixel_col <= '0;
			pixel_row <= '0;
			red_out   <= '0;
			green_out <= '0;
			blue_out  <= '0;
			last      <= 1'b0;
		end else begin
			if (out_valid && out_ready && !finish) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (pop) begin
						op_q     <= q_op;
						addr_q   <= head_addr;
						vld_rd_q <= rd_en ? valid_q[head_addr] : 1'b0;
						if (q_op.kind == OP_CLEAR) begin
							valid_q <= '0;
						end
						state_q <= B_RMW;
					end
				end
				B_RMW: begin
					if (finish) begin
						if (op_q.kind == OP_PLOT) begin
							valid_q[addr_q] <= 1'b1;
						end
						out_valid <= 1'b1;
						pixel_col <= op_q.col[3:0];
						pixel_row <= op_q.row[3:0];
						{red_out, green_out, blue_out} <=
							(op_q.kind == OP_PLOT) ? new_pix : pix;
						last    <= op_q.last;
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule

// File: sv/wu_subpixel_plot_engine.sv
// Antialiased subpixel plot engine over a 16x16 RGB frame store.
// A plot request spreads its colour over the four pixels around a 4.8 fixed-point
// position and returns one result per updated pixel inside the frame (last marks the
// final one); a read returns one pixel; a clear blackens the frame and returns one
// all-zero result. The front end issues one pixel op per cycle into a four-entry
// queue while the queue has room; the back end reads, then modifies and writes, each
// pixel op on the single port of the frame store, and finishes one op before it pops
// the next. Frame contents are tracked by a valid bit per pixel, so reset and clear
// take effect at once with no sweep of the store.
module wu_subpixel_plot_engine import wspe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        cmd,
	input  logic [11:0]       x_pos,
	input  logic [11:0]       y_pos,
	input  logic [CHAN_W-1:0] red_in,
	input  logic [CHAN_W-1:0] green_in,
	input  logic [CHAN_W-1:0] blue_in,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [3:0]        pixel_col,
	output logic [3:0]        pixel_row,
	output logic [CHAN_W-1:0] red_out,
	output logic [CHAN_W-1:0] green_out,
	output logic [CHAN_W-1:0] blue_out,
	output logic              last
);

	logic push, q_full, pop, q_empty;
	op_t  push_op, head_op;

	wspe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.x_pos    (x_pos),
		.y_pos    (y_pos),
		.red_in   (red_in),
		.green_in (green_in),
		.blue_in  (blue_in),
		.push     (push),
		.push_op  (push_op),
		.q_full   (q_full)
	);

	wspe_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.full    (q_full),
		.pop     (pop),
		.head_op (head_op),
		.empty   (q_empty)
	);

	wspe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_op      (head_op),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pixel_col (pixel_col),
		.pixel_row (pixel_row),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out),
		.last      (last)
	);

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the antialiased subpixel plot engine.
module tb_top import wspe_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int RANDOM_REQS  = 350;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int SETTLE_CYCLES = 40;

	typedef struct {
		logic [1:0]  cmd;
		logic [11:0] x_pos;
		logic [11:0] y_pos;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		bit          drain_first;
	} plot_req_t;

	typedef struct packed {
		logic [3:0] col;
		logic [3:0] row;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} pixel_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [1:0]        cmd = 2'd0;
	logic [11:0]       x_pos = 12'd0;
	logic [11:0]       y_pos = 12'd0;
	logic [CHAN_W-1:0] red_in = '0;
	logic [CHAN_W-1:0] green_in = '0;
	logic [CHAN_W-1:0] blue_in = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [3:0]        pixel_col;
	logic [3:0]        pixel_row;
	logic [CHAN_W-1:0] red_out;
	logic [CHAN_W-1:0] green_out;
	logic [CHAN_W-1:0] blue_out;
	logic              last;

	plot_req_t     pending_reqs[$];
	pixel_result_t pixel_expect_q[$];
	logic [23:0]   frame_shadow[MATRIX_HEIGHT][MATRIX_WIDTH];
	logic          frame_drained = 1'b1;
	int            mismatch_count = 0;
	int            accepted_count = 0;
	int            gap_left = 0;
	int            stall_left = 0;
	int unsigned   cycle_count = 0;

	wu_subpixel_plot_engine u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.x_pos     (x_pos),
		.y_pos     (y_pos),
		.red_in    (red_in),
		.green_in  (green_in),
		.blue_in   (blue_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pixel_col (pixel_col),
		.pixel_row (pixel_row),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out),
		.last      (last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// weight of one corner from a fraction pair
	function automatic int corner_wt(input int a, input int b);
		return (a * b + a + b) >> 8;
	endfunction

	// scale a channel by a weight and add it into a pixel channel, clamped
	function automatic logic [7:0] blend_chan(input logic [7:0] base, input logic [7:0] chan,
		input int wt);
		int sum;
		sum = int'(base) + ((int'(chan) * wt) >> 8);
		return (sum > 255) ? 8'hff : sum[7:0];
	endfunction

	function automatic void blacken_frame();
		for (int r = 0; r < MATRIX_HEIGHT; r++)
			for (int c = 0; c < MATRIX_WIDTH; c++)
				frame_shadow[r][c] = 24'h0;
	endfunction

	// update the shadow frame and queue the pixels a request should return
	function automatic void predict_pixels(input plot_req_t req);
		int            c0, r0, fx, fy, col, row;
		int            wts[4];
		logic [23:0]   px;
		pixel_result_t res;
		pixel_result_t batch[$];
		c0 = int'(req.x_pos[11:8]);
		r0 = int'(req.y_pos[11:8]);
		fx = int'(req.x_pos[7:0]);
		fy = int'(req.y_pos[7:0]);
		case (req.cmd)
		CMD_PLOT: begin
			wts[0] = corner_wt(255 - fx, 255 - fy);
			wts[1] = corner_wt(fx, 255 - fy);
			wts[2] = corner_wt(255 - fx, fy);
			wts[3] = corner_wt(fx, fy);
			for (int k = 0; k < 4; k++) begin
				col = c0 + (k % 2);
				row = r0 + (k / 2);
				if (col < MATRIX_WIDTH && row < MATRIX_HEIGHT) begin
					px = frame_shadow[row][col];
					px[23:16] = blend_chan(px[23:16], req.red, wts[k]);
					px[15:8]  = blend_chan(px[15:8], req.green, wts[k]);
					px[7:0]   = blend_chan(px[7:0], req.blue, wts[k]);
					frame_shadow[row][col] = px;
					res = '{col[3:0], row[3:0], px[23:16], px[15:8], px[7:0], 1'b0};
					batch.push_back(res);
				end
			end
		end
		CMD_READ: begin
			px = 24'h0;
			if (c0 < MATRIX_WIDTH && r0 < MATRIX_HEIGHT)
				px = frame_shadow[r0][c0];
			res = '{c0[3:0], r0[3:0], px[23:16], px[15:8], px[7:0], 1'b0};
			batch.push_back(res);
		end
		CMD_CLEAR: begin
			blacken_frame();
			res = '{4'd0, 4'd0, 8'd0, 8'd0, 8'd0, 1'b0};
			batch.push_back(res);
		end
		default: ;
		endcase
		if (batch.size() > 0)
			batch[batch.size() - 1].last = 1'b1;
		foreach (batch[i])
			pixel_expect_q.push_back(batch[i]);
	endfunction

	task automatic add_req(input logic [1:0] op, input logic [11:0] x, input logic [11:0] y,
		input logic [7:0] r, input logic [7:0] g, input logic [7:0] b, input bit drain);
		plot_req_t req;
		req = '{op, x, y, r, g, b, drain};
		pending_reqs.push_back(req);
	endtask

	// mostly anywhere, often on the last column or row to hit the frame edge
	function automatic logic [11:0] rand_pos();
		logic [11:0] p;
		p = 12'($urandom_range(0, 4095));
		case ($urandom_range(0, 7))
		0: p[11:8] = 4'hf;
		1: p[7:0] = 8'h00;
		2: p[7:0] = 8'hff;
		default: ;
		endcase
		return p;
	endfunction

	function automatic logic [7:0] rand_chan();
		case ($urandom_range(0, 9))
		0: return 8'h00;
		1: return 8'hff;
		default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// mostly short gaps, a few long ones, and gap-free bursts
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if ((accepted_count / 50) % 3 == 2)
			return 0;
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// stimulus and end of run
	initial begin
		int          issued;
		int          pick;
		logic [11:0] last_x, last_y;
		blacken_frame();
		add_req(CMD_READ, 12'h000, 12'h000, 8'h00, 8'h00, 8'h00, 1'b0);
		add_req(CMD_PLOT, 12'h000, 12'h000, 8'hff, 8'hff, 8'hff, 1'b0);
		add_req(CMD_PLOT, 12'h080, 12'h080, 8'h12, 8'h80, 8'hff, 1'b0);
		add_req(CMD_PLOT, 12'h080, 12'h080, 8'hff, 8'hff, 8'hff, 1'b0);
		add_req(CMD_PLOT, 12'h080, 12'h080, 8'hff, 8'hff, 8'hff, 1'b0);
		add_req(CMD_PLOT, 12'hfff, 12'hfff, 8'hff, 8'h00, 8'hff, 1'b0);
		add_req(CMD_PLOT, 12'hf40, 12'h7c0, 8'h80, 8'h40, 8'h20, 1'b0);
		add_req(CMD_PLOT, 12'h3a0, 12'hf10, 8'h33, 8'hcc, 8'h99, 1'b0);
		add_req(CMD_PLOT, 12'hf00, 12'h000, 8'hc0, 8'hc0, 8'hc0, 1'b0);
		add_req(CMD_PLOT, 12'h555, 12'haaa, 8'h00, 8'h00, 8'h00, 1'b0);
		add_req(CMD_READ, 12'h0ff, 12'h0ff, 8'hff, 8'hff, 8'hff, 1'b0);
		add_req(CMD_READ, 12'hfff, 12'hfff, 8'h00, 8'h00, 8'h00, 1'b0);
		add_req(CMD_READ, 12'h1ff, 12'h080, 8'h00, 8'h00, 8'h00, 1'b0);
		add_req(CMD_UNUSED, 12'hfff, 12'hfff, 8'hff, 8'hff, 8'hff, 1'b0);
		add_req(CMD_READ, 12'hf00, 12'h700, 8'h00, 8'h00, 8'h00, 1'b1);
		add_req(CMD_CLEAR, 12'hfff, 12'haaa, 8'hff, 8'h55, 8'hff, 1'b0);
		add_req(CMD_READ, 12'h000, 12'h000, 8'h00, 8'h00, 8'h00, 1'b0);
		add_req(CMD_READ, 12'hfff, 12'hfff, 8'h00, 8'h00, 8'h00, 1'b0);
		add_req(CMD_PLOT, 12'haaa, 12'h555, 8'haa, 8'h55, 8'h0f, 1'b0);
		add_req(CMD_PLOT, 12'h7ff, 12'h7ff, 8'h01, 8'hfe, 8'h7f, 1'b0);
		add_req(CMD_READ, 12'h800, 12'h800, 8'h00, 8'h00, 8'h00, 1'b0);

		// random mix: mostly plots, reads often aimed at the last plotted spot
		issued = 0;
		last_x = 12'h000;
		last_y = 12'h000;
		while (issued < RANDOM_REQS) begin
			pick = $urandom_range(0, 99);
			if (pick < 2) begin
				add_req(CMD_UNUSED, rand_pos(), rand_pos(), rand_chan(), rand_chan(),
					rand_chan(), 1'b0);
			end else begin
				if (pick < 72) begin
					last_x = rand_pos();
					last_y = rand_pos();
					add_req(CMD_PLOT, last_x, last_y, rand_chan(), rand_chan(), rand_chan(),
						$urandom_range(0, 99) < 3);
				end else if (pick < 94) begin
					if ($urandom_range(0, 1) == 0)
						add_req(CMD_READ, last_x + 12'((pick % 2) << 8), last_y, rand_chan(),
							rand_chan(), rand_chan(), 1'b0);
					else
						add_req(CMD_READ, rand_pos(), rand_pos(), rand_chan(), rand_chan(),
							rand_chan(), 1'b0);
				end else begin
					add_req(CMD_CLEAR, rand_pos(), rand_pos(), rand_chan(), rand_chan(),
						rand_chan(), $urandom_range(0, 3) == 0);
				end
				issued++;
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// hold until every request is taken and every pixel has come back
		while (pending_reqs.size() != 0 || in_valid || pixel_expect_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (pixel_expect_q.size() != 0)
			mismatch_count += pixel_expect_q.size();
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// request driver: advance through the pending list, with gaps and drain pauses
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				void'(pending_reqs.pop_front());
				accepted_count++;
				gap_left = pick_gap();
				// insert a gap so the drain flag sees this request's pixels
				if (pending_reqs.size() > 0 && pending_reqs[0].drain_first && gap_left == 0)
					gap_left = 1;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_reqs.size() == 0) begin
					in_valid <= 1'b0;
				end else if (pending_reqs[0].drain_first && !frame_drained) begin
					in_valid <= 1'b0;
				end else begin
					in_valid <= 1'b1;
					cmd      <= pending_reqs[0].cmd;
					x_pos    <= pending_reqs[0].x_pos;
					y_pos    <= pending_reqs[0].y_pos;
					red_in   <= pending_reqs[0].red;
					green_in <= pending_reqs[0].green;
					blue_in  <= pending_reqs[0].blue;
				end
			end
		end
	end

	// result side backpressure: short and long stalls, with stall-free stretches
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if ((cycle_count / 2000) % 4 == 3 || $urandom_range(0, 99) < 70) begin
			out_ready <= 1'b1;
		end else begin
			stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
				: $urandom_range(0, 2);
			out_ready <= 1'b0;
		end
	end

	// monitor: check returned pixels, then predict for the request taken this edge
	always @(posedge clk) begin
		pixel_result_t got;
		pixel_result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = '{pixel_col, pixel_row, red_out, green_out, blue_out, last};
				if (pixel_expect_q.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: unexpected pixel col=%0d row=%0d rgb=%h %h %h last=%b",
							$realtime, got.col, got.row, got.red, got.green, got.blue, got.last);
				end else begin
					want = pixel_expect_q.pop_front();
					if (got.col !== want.col || got.row !== want.row || got.red !== want.red ||
						got.green !== want.green || got.blue !== want.blue ||
						got.last !== want.last) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("%0t: pixel mismatch exp col=%0d row=%0d rgb=%h %h %h ",
								$realtime, want.col, want.row, want.red, want.green, want.blue,
								"last=%b, got col=%0d row=%0d rgb=%h %h %h last=%b",
								want.last, got.col, got.row, got.red, got.green, got.blue,
								got.last);
					end
				end
			end
			if (in_valid && in_ready)
				predict_pixels('{cmd, x_pos, y_pos, red_in, green_in, blue_in, 1'b0});
		end
		frame_drained <= (pixel_expect_q.size() == 0);
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

endmodule
